### rtl/core/double_hash_table_insert_defines.svh
// Assertion macros used by the checker file of the double hash table insert block.
`ifndef DOUBLE_HASH_TABLE_INSERT_DEFINES_SVH
`define DOUBLE_HASH_TABLE_INSERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DHTI_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DHTI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked during reset.
`define DHTI_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/dhti_pkg.sv
// Shared widths, types and status codes of the double hash table insert block.
`default_nettype none

package dhti_pkg;

   localparam int KEY_W    = 24;
   localparam int TAG_W    = 32;
   localparam int NAME_W   = 16;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 10;
   localparam int SIZE_W   = 11;
   localparam int BIT_CNT_W = $clog2(KEY_W);
   localparam int ENTRY_W  = KEY_W + TAG_W + NAME_W;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [TAG_W-1:0]    tag_type;
   typedef logic [NAME_W-1:0]   name_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [SIZE_W-1:0]   size_type;

   localparam size_type SIZE_RESET = 11'd1021;
   localparam size_type SIZE_MIN   = 11'd3;

   localparam status_type ST_HOME      = 3'd0;
   localparam status_type ST_PROBED    = 3'd1;
   localparam status_type ST_DUPLICATE = 3'd2;
   localparam status_type ST_FULL      = 3'd3;
   localparam status_type ST_ZERO_KEY  = 3'd4;

   localparam logic REG_TABLE_SIZE = 1'b0;

endpackage

`default_nettype wire

### rtl/core/dhti_if.sv
// Request and response channel interfaces of the double hash table insert block.
`default_nettype none

interface dhti_req_if;
   import dhti_pkg::*;

   logic     valid;
   logic     ready;
   key_type  item_key;
   tag_type  content_tag;
   name_type name_handle;

   modport source (output valid, output item_key, output content_tag, output name_handle,
                   input ready);
   modport sink (input valid, input item_key, input content_tag, input name_handle,
                 output ready);
endinterface

interface dhti_rsp_if;
   import dhti_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   idx_type    slot_index;
   idx_type    probe_count;

   modport source (output valid, output status, output slot_index, output probe_count,
                   input ready);
   modport sink (input valid, input status, input slot_index, input probe_count,
                 output ready);
endinterface

`default_nettype wire

### rtl/core/dhti_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dhti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/double_hash_table_insert.sv
// Double hashing insert into an open-addressed table of up to TABLE_DEPTH slots.
// After reset a clearing pass writes zero to every slot while req_ch.ready is low.
// A zero key goes straight to the response; others fill the home slot, report a duplicate
// there, or probe with a second hash step until a free slot or a full table is found.
// Remainders are serial (one key bit per cycle), one read per probe; one request at a time.
`default_nettype none

module double_hash_table_insert #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   dhti_req_if.sink                            req_ch,
   dhti_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [dhti_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [dhti_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [dhti_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import dhti_pkg::*;

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int DEPTH_CAP = (TABLE_DEPTH > (1 << SIZE_W) - 1) ? (1 << SIZE_W) - 1 : TABLE_DEPTH;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD_HOME,
      S_RD_HOME,
      S_CHK_HOME,
      S_MOD_STEP,
      S_STEP_FIX,
      S_PROBE_FIRST,
      S_PROBE,
      S_RESP
   } state_type;

   state_type              state_ff, state_in;
   size_type               size_ff, size_in;
   key_type                key_ff, key_in;
   tag_type                tag_ff, tag_in;
   name_type               name_ff, name_in;
   key_type                div_key_ff, div_key_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   size_type               rem_ff, rem_in;
   size_type               home_ff, home_in;
   size_type               step_ff, step_in;
   size_type               pos_ff, pos_in;
   size_type               probe_ff, probe_in;
   logic [AW-1:0]          clr_ff, clr_in;
   status_type             res_status_ff, res_status_in;
   idx_type                res_slot_ff, res_slot_in;
   idx_type                res_probes_ff, res_probes_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   idx_type                rsp_slot_ff, rsp_slot_in;
   idx_type                rsp_probes_ff, rsp_probes_in;

   size_type               m_size;
   size_type               unit_d;
   logic [SIZE_W:0]        unit_a;
   size_type               unit_y;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [AW-1:0]          ram_raddr;
   logic [ENTRY_W-1:0]     ram_wdata;
   logic [ENTRY_W-1:0]     ram_rdata;
   key_type                rd_key;
   tag_type                rd_tag;
   logic                   last_bit;
   logic                   req_accept;
   logic                   csr_write;

   dhti_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_key = ram_rdata[ENTRY_W-1 -: KEY_W];
   assign rd_tag = ram_rdata[TAG_W+NAME_W-1 -: TAG_W];

   always_comb begin
      if (size_ff < SIZE_MIN) begin
         m_size = SIZE_MIN;
      end else if (size_ff > SIZE_W'(DEPTH_CAP)) begin
         m_size = SIZE_W'(DEPTH_CAP);
      end else begin
         m_size = size_ff;
      end
   end

   always_comb begin
      case (state_ff)
         S_MOD_HOME, S_MOD_STEP: unit_a = {rem_ff, div_key_ff[KEY_W-1]};
         S_STEP_FIX:             unit_a = {1'b0, rem_ff} + (SIZE_W+1)'(1);
         S_PROBE_FIRST:          unit_a = {1'b0, home_ff} + {1'b0, step_ff};
         S_PROBE:                unit_a = {1'b0, pos_ff} + {1'b0, step_ff};
         default:                unit_a = '0;
      endcase
      unit_d = (state_ff == S_MOD_STEP) ? m_size - SIZE_W'(1) : m_size;
      unit_y = (unit_a >= {1'b0, unit_d}) ? SIZE_W'(unit_a - {1'b0, unit_d})
                                          : SIZE_W'(unit_a);
   end

   assign last_bit   = (bit_cnt_ff == BIT_CNT_W'(KEY_W - 1));
   assign req_accept = req_ch.valid && (state_ff == S_IDLE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_TABLE_SIZE);

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      name_in       = name_ff;
      div_key_in    = div_key_ff;
      bit_cnt_in    = bit_cnt_ff;
      rem_in        = rem_ff;
      home_in       = home_ff;
      step_in       = step_ff;
      pos_in        = pos_ff;
      probe_in      = probe_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_probes_in = res_probes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_probes_in = rsp_probes_ff;
      ram_we        = 1'b0;
      ram_waddr     = AW'(home_ff);
      ram_wdata     = {key_ff, tag_ff, name_ff};
      ram_raddr     = AW'(home_ff);

      if (csr_write) begin
         size_in = csr_pwdata[SIZE_W-1:0];
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               key_in     = req_ch.item_key;
               tag_in     = req_ch.content_tag;
               name_in    = req_ch.name_handle;
               div_key_in = req_ch.item_key;
               rem_in     = '0;
               bit_cnt_in = '0;
               if (req_ch.item_key == '0) begin
                  res_status_in = ST_ZERO_KEY;
                  res_slot_in   = '0;
                  res_probes_in = '0;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_MOD_HOME;
               end
            end
         end
         S_MOD_HOME: begin
            rem_in     = unit_y;
            div_key_in = div_key_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (last_bit) begin
               home_in  = unit_y;
               state_in = S_RD_HOME;
            end
         end
         S_RD_HOME: begin
            state_in = S_CHK_HOME;
         end
         S_CHK_HOME: begin
            if (rd_key == '0) begin
               ram_we        = 1'b1;
               res_status_in = ST_HOME;
               res_slot_in   = IDX_W'(home_ff);
               res_probes_in = '0;
               state_in      = S_RESP;
            end else if (rd_tag == tag_ff) begin
               res_status_in = ST_DUPLICATE;
               res_slot_in   = IDX_W'(home_ff);
               res_probes_in = '0;
               state_in      = S_RESP;
            end else begin
               rem_in     = '0;
               div_key_in = key_ff;
               bit_cnt_in = '0;
               state_in   = S_MOD_STEP;
            end
         end
         S_MOD_STEP: begin
            rem_in     = unit_y;
            div_key_in = div_key_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (last_bit) begin
               state_in = S_STEP_FIX;
            end
         end
         S_STEP_FIX: begin
            step_in  = unit_y;
            state_in = S_PROBE_FIRST;
         end
         S_PROBE_FIRST: begin
            pos_in    = unit_y;
            ram_raddr = AW'(unit_y);
            probe_in  = SIZE_W'(1);
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            if (rd_key == '0) begin
               ram_we        = 1'b1;
               ram_waddr     = AW'(pos_ff);
               res_status_in = ST_PROBED;
               res_slot_in   = IDX_W'(pos_ff);
               res_probes_in = IDX_W'(probe_ff);
               state_in      = S_RESP;
            end else if (probe_ff == m_size - SIZE_W'(1)) begin
               res_status_in = ST_FULL;
               res_slot_in   = IDX_W'(home_ff);
               res_probes_in = IDX_W'(probe_ff);
               state_in      = S_RESP;
            end else begin
               pos_in    = unit_y;
               ram_raddr = AW'(unit_y);
               probe_in  = probe_ff + SIZE_W'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_probes_in = res_probes_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         size_ff      <= SIZE_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      name_ff       <= name_in;
      div_key_ff    <= div_key_in;
      bit_cnt_ff    <= bit_cnt_in;
      rem_ff        <= rem_in;
      home_ff       <= home_in;
      step_ff       <= step_in;
      pos_ff        <= pos_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_probes_ff <= res_probes_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probes_ff <= rsp_probes_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.slot_index  = rsp_slot_ff;
   assign rsp_ch.probe_count = rsp_probes_ff;

   assign csr_prdata = (csr_paddr[2] == REG_TABLE_SIZE) ? CSR_DW'(size_ff) : '0;
   assign csr_pready = 1'b1;

endmodule

`default_nettype wire

### rtl/core/dhti_chk.sv
// Port-level checker of the double hash table insert block and its bind statement.
`default_nettype none
`include "double_hash_table_insert_defines.svh"

module dhti_chk (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [dhti_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [dhti_pkg::IDX_W-1:0]    rsp_slot_index,
   input wire logic [dhti_pkg::IDX_W-1:0]    rsp_probe_count
);
   import dhti_pkg::*;

   `DHTI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index) && $stable(rsp_probe_count),
      "Response transaction changed while stalled.")

   `DHTI_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
      "Request ready stayed high after an accepted transaction.")

   `DHTI_ASSERT(a_no_probes, rsp_valid && (rsp_status == ST_HOME || rsp_status == ST_DUPLICATE),
      rsp_probe_count == '0, "Probe count is nonzero for a home slot or duplicate result.")

   `DHTI_ASSERT(a_zero_key, rsp_valid && rsp_status == ST_ZERO_KEY,
      rsp_slot_index == '0 && rsp_probe_count == '0, "Zero key result is not all zero.")

   `DHTI_ASSERT_RST(a_reset_quiet, reset, !rsp_valid && !req_ready,
      "Channels are not quiet after reset.")

endmodule

bind double_hash_table_insert dhti_chk u_dhti_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_slot_index  (rsp_ch.slot_index),
   .rsp_probe_count (rsp_ch.probe_count)
);

`default_nettype wire

### tb/tb_double_hash_table_insert.sv
// Self-checking testbench for the double hash table insert block with its own table predictor.
`timescale 1ns / 100ps

module tb_double_hash_table_insert;
   import dhti_pkg::*;

   localparam int TABLE_DEPTH = 1024;
   localparam logic [CSR_AW-1:0] TABLE_SIZE_ADDR = {REG_TABLE_SIZE, 2'b00};
   // Byte address of register index one, which the block does not implement.
   localparam logic [CSR_AW-1:0] SPARE_ADDR = 3'd4;

   typedef struct packed {
      key_type  key;
      tag_type  tag;
      name_type name;
      logic     drain_first;
   } insert_req_type;

   typedef struct packed {
      status_type status;
      idx_type    slot_index;
      idx_type    probe_count;
   } insert_outcome_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   dhti_req_if req_bus ();
   dhti_rsp_if rsp_bus ();

   double_hash_table_insert #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   key_type  tbl_key_mem  [TABLE_DEPTH];
   tag_type  tbl_tag_mem  [TABLE_DEPTH];
   name_type tbl_name_mem [TABLE_DEPTH];
   size_type size_reg;

   insert_req_type     insert_q [$];
   insert_outcome_type outcome_q [$];
   key_type            seen_keys [$];
   tag_type            seen_tags [$];

   int unsigned mismatch_count = 0;
   logic        req_busy = 1'b0;
   logic        req_took = 1'b0;
   logic        req_steady = 1'b0;
   int unsigned req_gap = 0;
   logic        rsp_took = 1'b0;
   logic        rsp_steady = 1'b0;
   int unsigned rsp_wait = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb_double_hash_table_insert: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      $display("MISMATCH at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
   endtask

   function automatic int unsigned slots_in_use();
      if (size_reg < SIZE_MIN) begin
         return SIZE_MIN;
      end
      if (size_reg > TABLE_DEPTH) begin
         return TABLE_DEPTH;
      end
      return size_reg;
   endfunction

   function automatic void record_entry(input int unsigned pos, input key_type key,
                                        input tag_type tag, input name_type name);
      tbl_key_mem[pos] = key;
      tbl_tag_mem[pos] = tag;
      tbl_name_mem[pos] = name;
   endfunction

   function automatic insert_outcome_type predict_insert(input key_type key, input tag_type tag,
                                                         input name_type name);
      insert_outcome_type res;
      int unsigned m;
      int unsigned home;
      int unsigned stride;
      int unsigned pos;
      m = slots_in_use();
      res.status = ST_ZERO_KEY;
      res.slot_index = '0;
      res.probe_count = '0;
      if (key == '0) begin
         return res;
      end
      home = key % m;
      res.slot_index = idx_type'(home);
      if (tbl_key_mem[home] == '0) begin
         record_entry(home, key, tag, name);
         res.status = ST_HOME;
         return res;
      end
      if (tbl_tag_mem[home] == tag) begin
         res.status = ST_DUPLICATE;
         return res;
      end
      stride = 1 + key % (m - 1);
      if (stride >= m) begin
         stride -= m;
      end
      pos = home;
      for (int unsigned i = 1; i < m; i++) begin
         pos += stride;
         if (pos >= m) begin
            pos -= m;
         end
         if (tbl_key_mem[pos] == '0) begin
            record_entry(pos, key, tag, name);
            res.status = ST_PROBED;
            res.slot_index = idx_type'(pos);
            res.probe_count = idx_type'(i);
            return res;
         end
      end
      res.status = ST_FULL;
      res.probe_count = idx_type'(m - 1);
      return res;
   endfunction

   task automatic add_insert(input key_type key, input tag_type tag, input name_type name,
                             input logic drain_first);
      insert_req_type r;
      r.key = key;
      r.tag = tag;
      r.name = name;
      r.drain_first = drain_first;
      insert_q.push_back(r);
   endtask

   // Most requests reuse recent keys and tags so that duplicates and probe chains are common.
   task automatic queue_random_insert();
      int unsigned pick;
      int unsigned m;
      int unsigned j;
      key_type k;
      tag_type t;
      name_type n;
      m = slots_in_use();
      k = key_type'($urandom());
      t = $urandom();
      n = name_type'($urandom());
      pick = $urandom_range(0, 99);
      j = 0;
      if (seen_keys.size() == 0) begin
         pick = 0;
      end else begin
         j = $urandom_range(0, seen_keys.size() - 1);
      end
      if (pick < 35) begin
         if (k == '0) begin
            k = 24'd1;
         end
      end else if (pick < 55) begin
         k = seen_keys[j];
         t = seen_tags[j];
      end else if (pick < 72) begin
         k = seen_keys[j] + key_type'(m * $urandom_range(1, 4));
         t = seen_tags[j];
      end else if (pick < 88) begin
         k = seen_keys[j];
      end else if (pick < 94) begin
         k = '0;
      end else begin
         case ($urandom_range(0, 3))
            0: k = 24'hFF_FFFF;
            1: k = 24'd1;
            2: k = key_type'(m);
            default: k = key_type'(m - 1);
         endcase
         t = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         n = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      end
      if (k != '0) begin
         seen_keys.push_back(k);
         seen_tags.push_back(t);
         if (seen_keys.size() > 24) begin
            void'(seen_keys.pop_front());
            void'(seen_tags.pop_front());
         end
      end
      add_insert(k, t, n, $urandom_range(0, 39) == 0);
   endtask

   task automatic wait_idle();
      while (insert_q.size() != 0 || req_busy || outcome_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_table_size();
      logic [CSR_DW-1:0] readback;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= TABLE_SIZE_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      readback = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== CSR_DW'(size_reg)) begin
         report_mismatch("table_size readback", readback, size_reg);
      end
   endtask

   task automatic set_table_size(input logic [CSR_DW-1:0] value);
      wait_idle();
      csr_write(TABLE_SIZE_ADDR, value);
      size_reg = value[SIZE_W-1:0];
      check_table_size();
   endtask

   always @(negedge clock) begin : drive_requests
      logic next_valid;
      insert_req_type r;
      next_valid = req_bus.valid;
      if (!reset) begin
         if (req_took) begin
            req_took = 1'b0;
            req_busy = 1'b0;
            next_valid = 1'b0;
            if ($urandom_range(0, 19) == 0) begin
               req_steady = !req_steady;
            end
            req_gap = req_steady ? 0 : $urandom_range(0, 12);
         end
         if (!req_busy) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (insert_q.size() != 0 &&
                         (!insert_q[0].drain_first || outcome_q.size() == 0)) begin
               r = insert_q.pop_front();
               req_bus.item_key <= r.key;
               req_bus.content_tag <= r.tag;
               req_bus.name_handle <= r.name;
               next_valid = 1'b1;
               req_busy = 1'b1;
            end
         end
         req_bus.valid <= next_valid;
      end
   end

   always @(negedge clock) begin : drive_results_ready
      if (!reset) begin
         if (rsp_took) begin
            rsp_took = 1'b0;
            if ($urandom_range(0, 19) == 0) begin
               rsp_steady = !rsp_steady;
            end
            rsp_wait = rsp_steady ? 0 : $urandom_range(0, 12);
         end
         if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch_channels
      insert_outcome_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            outcome_q.push_back(predict_insert(req_bus.item_key, req_bus.content_tag,
                                               req_bus.name_handle));
            req_took = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_took = 1'b1;
            if (outcome_q.size() == 0) begin
               report_mismatch("unrequested transaction, status", rsp_bus.status, 0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_bus.status !== want.status) begin
                  report_mismatch("status", rsp_bus.status, want.status);
               end
               if (rsp_bus.slot_index !== want.slot_index) begin
                  report_mismatch("slot_index", rsp_bus.slot_index, want.slot_index);
               end
               if (rsp_bus.probe_count !== want.probe_count) begin
                  report_mismatch("probe_count", rsp_bus.probe_count, want.probe_count);
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.item_key = '0;
      req_bus.content_tag = '0;
      req_bus.name_handle = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      size_reg = SIZE_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         record_entry(i, '0, '0, '0);
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_table_size();

      add_insert(24'd0, 32'h0, 16'h0, 1'b0);
      add_insert(24'hFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      add_insert(24'd1, 32'hA5A5_A5A5, 16'h0001, 1'b0);
      add_insert(24'd1, 32'hA5A5_A5A5, 16'h8000, 1'b1);
      add_insert(24'd1022, 32'hA5A5_A5A5, 16'h1234, 1'b0);
      add_insert(24'd1022, 32'h5A5A_5A5A, 16'h4321, 1'b0);
      add_insert(24'd2043, 32'h1234_5678, 16'hFFFF, 1'b0);
      add_insert(24'd4, 32'h0F0F_0F0F, 16'h0000, 1'b0);
      add_insert(24'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      repeat (80) queue_random_insert();

      set_table_size(32'd3);
      add_insert(24'd3, 32'hC001_0003, 16'h0003, 1'b0);
      add_insert(24'd5, 32'hC001_0005, 16'h0005, 1'b0);
      add_insert(24'd6, 32'hC001_0006, 16'h0006, 1'b0);
      add_insert(24'd9, 32'hC001_0003, 16'h0009, 1'b0);
      repeat (30) queue_random_insert();

      wait_idle();
      csr_write(SPARE_ADDR, 32'd5);
      check_table_size();

      set_table_size(32'd0);
      repeat (15) queue_random_insert();
      set_table_size(32'd1024);
      repeat (80) queue_random_insert();
      set_table_size(32'hFFFF_FFFF);
      repeat (40) queue_random_insert();
      set_table_size(32'd9);
      repeat (40) queue_random_insert();
      set_table_size(32'd2);
      repeat (10) queue_random_insert();
      set_table_size(32'd1);
      repeat (10) queue_random_insert();
      set_table_size(32'd17);
      repeat (60) queue_random_insert();
      set_table_size(32'd101);
      repeat (80) queue_random_insert();
      set_table_size(32'd1021);
      repeat (75) queue_random_insert();

      wait_idle();
      repeat (1200) @(negedge clock);
      if (outcome_q.size() != 0) begin
         report_mismatch("transactions still outstanding", 0, outcome_q.size());
      end
      if (mismatch_count == 0) begin
         $display("tb_double_hash_table_insert: done, clean");
      end else begin
         $display("tb_double_hash_table_insert: done, errors");
      end
      $finish;
   end

endmodule

### double_hash_table_insert.f
+incdir+rtl/core
rtl/core/dhti_pkg.sv
rtl/core/dhti_if.sv
rtl/core/dhti_ram.sv
rtl/core/double_hash_table_insert.sv
rtl/core/dhti_chk.sv
tb/tb_double_hash_table_insert.sv
